### src/fpfa_pkg.sv
// Package for the FIFO page-frame allocator: widths, reset values,
// status and register index codes. No dependencies.
package fpfa_pkg;

   localparam int ADDR_W         = 32;
   localparam int STATUS_W       = 3;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 32;

   localparam int DEF_MAX_PAGES  = 32768;
   localparam int DEF_PAGE_SHIFT = 12;

   localparam logic [ADDR_W-1:0] DEF_REGION_START = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] DEF_REGION_TOP   = 32'h8800_0000;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOC = 3'd0,
      ST_EMPTY = 3'd1,
      ST_FREED = 3'd2,
      ST_BAD   = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_START = 1'b0,
      CSR_REGION_TOP   = 1'b1
   } csr_index_type;

endpackage

### src/fpfa_ifs.sv
// Valid/ready channel interfaces for allocator requests and responses.
// Depends on fpfa_pkg.
interface fpfa_req_if;
   import fpfa_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] page_addr;
   modport source (output valid, output func, output page_addr, input ready);
   modport sink   (input valid, input func, input page_addr, output ready);
endinterface

interface fpfa_rsp_if;
   import fpfa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_addr;
   modport source (output valid, output status, output result_addr, input ready);
   modport sink   (input valid, input status, input result_addr, output ready);
endinterface

### src/fpfa_ring_ram.sv
// Single-port-write, single-port-read ring storage of freed page numbers.
// Registered read data. Depends on nothing.
module fpfa_ring_ram #(
   parameter int DEPTH  = 32768,
   parameter int DATA_W = 20,
   parameter int IDX_W  = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_idx,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_idx,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fifo_page_frame_allocator.sv
// Top level of the FIFO page-frame allocator: request register, decision
// logic, result register, ring RAM. Depends on fpfa_pkg, fpfa_ifs, fpfa_ring_ram.
//
//   channel | dir | beat payload              | handshake
//   --------+-----+---------------------------+------------------
//   req     | in  | func, page_addr           | valid & ready
//   rsp     | out | status, result_addr       | valid & ready
//   csr     | in  | csr_index, csr_wdata      | csr_we
//
// One beat per cycle in each direction while the response is not stalled;
// a request beat passes the request register, then the result register
// with the ring RAM read. Reset is synchronous, clears pointers and counts,
// sets regions to defaults, leaves the ring RAM uncleared. A stalled response
// holds, and the request register still accepts one more beat behind it.
module fifo_page_frame_allocator #(
   parameter int MAX_PAGES  = fpfa_pkg::DEF_MAX_PAGES,
   parameter int PAGE_SHIFT = fpfa_pkg::DEF_PAGE_SHIFT
) (
   input  logic                            clock,
   input  logic                            reset,
   fpfa_req_if.sink                        req_chan,
   fpfa_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpfa_pkg::*;

   localparam int PN_W  = ADDR_W - PAGE_SHIFT;
   localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNT_W = $clog2(MAX_PAGES + 1);

   localparam logic [ADDR_W:0]   PG_MASK   = (33'd1 << PAGE_SHIFT) - 33'd1;
   localparam logic [ADDR_W:0]   DEF_BASE  = ({1'b0, DEF_REGION_START} + PG_MASK) & ~PG_MASK;
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(MAX_PAGES - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(MAX_PAGES);
   localparam logic [ADDR_W:0]   MAX_WIDE  = (ADDR_W+1)'(MAX_PAGES);

   // configuration and derived region values
   logic [ADDR_W-1:0] start_ff, top_ff;
   logic [ADDR_W:0]   base_ff, base_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [ADDR_W+1:0] span;
   logic [ADDR_W:0]   span_pages;

   // allocator state
   logic [CNT_W-1:0]  issued_ff, issued_in;
   logic [IDX_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // pipeline
   logic              s1_v_ff;
   logic              s1_func_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s2_v_ff;
   status_type        s2_status_ff, s2_status_in;
   logic [ADDR_W-1:0] s2_addr_ff, s2_addr_in;
   logic              s2_ring_ff, s2_ring_in;

   logic              s2_free, s1_go, req_take;
   logic              ram_we, ram_re;
   logic [PN_W-1:0]   ram_rdata;

   assign s2_free  = !s2_v_ff || rsp_chan.ready;
   assign s1_go    = s1_v_ff && s2_free;
   assign req_chan.ready = !reset && (!s1_v_ff || s2_free);
   assign req_take = req_chan.valid && req_chan.ready;

   // region registers; the rounded-up base is formed on the write itself
   assign base_in = ({1'b0, csr_wdata} + PG_MASK) & ~PG_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= DEF_REGION_START;
         top_ff   <= DEF_REGION_TOP;
         base_ff  <= DEF_BASE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REGION_START: begin
               start_ff <= csr_wdata;
               base_ff  <= base_in;
            end
            CSR_REGION_TOP: top_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fresh page total, registered from the region registers in the cycle after they change
   always_comb begin
      span       = {2'b00, top_ff} - {1'b0, base_ff};
      span_pages = span[ADDR_W:0] >> PAGE_SHIFT;
      if (span[ADDR_W+1] || span_pages == '0) begin
         total_in = '0;
      end else if (span_pages > MAX_WIDE) begin
         total_in = CNT_FULL;
      end else begin
         total_in = span_pages[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   // decision for the beat in the request register
   always_comb begin
      issued_in    = issued_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      s2_status_in = ST_EMPTY;
      s2_addr_in   = '0;
      s2_ring_in   = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      if (!s1_func_ff) begin
         priority if (total_ff > issued_ff) begin
            s2_status_in = ST_ALLOC;
            s2_addr_in   = base_ff[ADDR_W-1:0] + (ADDR_W'(issued_ff) << PAGE_SHIFT);
            issued_in    = issued_ff + CNT_W'(1);
         end else if (count_ff != '0) begin
            s2_status_in = ST_ALLOC;
            s2_ring_in   = 1'b1;
            ram_re       = s1_go;
            head_in      = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
            count_in     = count_ff - CNT_W'(1);
         end else begin
            s2_status_in = ST_EMPTY;
         end
      end else begin
         priority if (s1_addr_ff[PAGE_SHIFT-1:0] != '0 || s1_addr_ff < start_ff ||
                      s1_addr_ff >= top_ff) begin
            s2_status_in = ST_BAD;
         end else if (count_ff == CNT_FULL) begin
            s2_status_in = ST_FULL;
         end else begin
            s2_status_in = ST_FREED;
            ram_we       = s1_go;
            tail_in      = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);
            count_in     = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else if (s1_go) begin
         issued_ff <= issued_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_take) begin
         s1_v_ff <= 1'b1;
      end else if (s1_go) begin
         s1_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff <= req_chan.func;
         s1_addr_ff <= req_chan.page_addr;
      end
   end

   // result register; ring data lands in the RAM's read register alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_status_ff <= s2_status_in;
         s2_addr_ff   <= s2_addr_in;
         s2_ring_ff   <= s2_ring_in;
      end
   end

   fpfa_ring_ram #(
      .DEPTH  (MAX_PAGES),
      .DATA_W (PN_W),
      .IDX_W  (IDX_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_idx  (tail_ff),
      .wr_data (s1_addr_ff[ADDR_W-1:PAGE_SHIFT]),
      .rd_en   (ram_re),
      .rd_idx  (head_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_chan.valid       = s2_v_ff;
   assign rsp_chan.status      = s2_status_ff;
   assign rsp_chan.result_addr = s2_ring_ff ? {ram_rdata, PAGE_SHIFT'(0)} : s2_addr_ff;

endmodule

### src/fpfa_checker.sv
// Port-level checks on the allocator's response channel, bound to the top.
// Depends on fpfa_pkg and fifo_page_frame_allocator.
module fpfa_checker #(
   parameter int PAGE_SHIFT = fpfa_pkg::DEF_PAGE_SHIFT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fpfa_pkg::STATUS_W-1:0] rsp_status,
   input logic [fpfa_pkg::ADDR_W-1:0]   rsp_result_addr
);
   import fpfa_pkg::*;

   // a stalled beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_result_addr))
      else $error("response changed while stalled");

   // only a successful allocate carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ALLOC |-> rsp_result_addr == '0)
      else $error("nonzero address on non-allocate response");

   // allocated addresses are page aligned
   a_addr_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ALLOC |-> rsp_result_addr[PAGE_SHIFT-1:0] == '0)
      else $error("allocated address not page aligned");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind fifo_page_frame_allocator fpfa_checker #(
   .PAGE_SHIFT (PAGE_SHIFT)
) u_fpfa_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_result_addr (rsp_chan.result_addr)
);

### test/fifo_page_frame_allocator_tb.sv
// Testbench for fifo_page_frame_allocator: queue-fed request driver, response
// checker against an in-bench allocator model, region register writes per phase.
// Depends on fpfa_pkg, fpfa_ifs and the allocator RTL.
module fifo_page_frame_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpfa_pkg::*;

   localparam int CLK_PERIOD = 10;
   localparam int MAX_PAGES  = DEF_MAX_PAGES;
   localparam int PAGE_SHIFT = DEF_PAGE_SHIFT;
   localparam int PN_W       = ADDR_W - PAGE_SHIFT;
   localparam int LATENCY    = 2;
   localparam int STALL_MAX  = 2000;
   localparam int RAND_ITEMS = 510;
   localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] page_addr;
   } page_req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] addr;
   } alloc_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fpfa_req_if req_if ();
   fpfa_rsp_if rsp_if ();

   fifo_page_frame_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // allocator model state
   logic [ADDR_W-1:0] region_start_q = DEF_REGION_START;
   logic [ADDR_W-1:0] region_top_q   = DEF_REGION_TOP;
   int unsigned       fresh_issued   = 0;
   logic [PN_W-1:0]   freed_pages [MAX_PAGES];
   int unsigned       ring_head      = 0;
   int unsigned       ring_tail      = 0;
   int unsigned       ring_count     = 0;

   page_req_type      page_req_q[$];
   alloc_outcome_type alloc_outcomes_q[$];
   int                send_idle_pct  = 0;
   int                recv_idle_pct  = 0;
   int                mismatch_count = 0;

   function automatic logic [63:0] region_base();
      return ({32'h0, region_start_q} + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
   endfunction

   function automatic int unsigned fresh_page_count();
      logic [63:0] base;
      logic [63:0] n;
      base = region_base();
      if (base + PAGE_BYTES > {32'h0, region_top_q}) return 0;
      n = ({32'h0, region_top_q} - base) >> PAGE_SHIFT;
      if (n > MAX_PAGES) n = MAX_PAGES;
      return int'(n);
   endfunction

   function automatic alloc_outcome_type next_alloc_outcome(logic f, logic [ADDR_W-1:0] a);
      alloc_outcome_type r;
      logic [63:0] base;
      r.status = ST_EMPTY;
      r.addr   = '0;
      if (f == FUNC_ALLOC) begin
         base = region_base();
         // fresh pages first, then the ring of freed pages
         if (fresh_page_count() > fresh_issued) begin
            r.status = ST_ALLOC;
            r.addr   = ADDR_W'(base + (64'(fresh_issued) << PAGE_SHIFT));
            fresh_issued++;
         end else if (ring_count > 0) begin
            r.status   = ST_ALLOC;
            r.addr     = {freed_pages[ring_head], {PAGE_SHIFT{1'b0}}};
            ring_head  = (ring_head + 1 >= MAX_PAGES) ? 0 : ring_head + 1;
            ring_count--;
         end
      end else if (a[PAGE_SHIFT-1:0] != '0 || a < region_start_q || a >= region_top_q) begin
         r.status = ST_BAD;
      end else if (ring_count >= MAX_PAGES) begin
         r.status = ST_FULL;
      end else begin
         freed_pages[ring_tail] = a[ADDR_W-1:PAGE_SHIFT];
         ring_tail  = (ring_tail + 1 >= MAX_PAGES) ? 0 : ring_tail + 1;
         ring_count++;
         r.status   = ST_FREED;
      end
      return r;
   endfunction

   task automatic note_mismatch(string what, logic [STATUS_W-1:0] got_st,
                                logic [ADDR_W-1:0] got_addr, alloc_outcome_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: status %0d addr %h, expected status %0d addr %h",
                  $time, what, got_st, got_addr, want.status, want.addr);
   endtask

   task automatic queue_req(func_type f, logic [ADDR_W-1:0] a);
      page_req_type item;
      item.func      = f;
      item.page_addr = a;
      page_req_q.push_back(item);
   endtask

   task automatic write_region(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_REGION_START: region_start_q = value;
         CSR_REGION_TOP:   region_top_q   = value;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (page_req_q.size() != 0 || alloc_outcomes_q.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic queue_random_reqs(int count);
      logic [63:0]       base;
      logic [63:0]       pages;
      logic [ADDR_W-1:0] a;
      int                pick;
      for (int k = 0; k < count; k++) begin
         base  = region_base();
         pages = ({32'h0, region_top_q} > base) ?
                 (({32'h0, region_top_q} - base) >> PAGE_SHIFT) : 64'd0;
         pick  = $urandom_range(99);
         if ($urandom_range(1) == 0) begin
            queue_req(FUNC_ALLOC, $urandom);
         end else begin
            if (pick < 65 && pages != 0)
               a = ADDR_W'(base + (64'($urandom_range(32'(pages - 1))) << PAGE_SHIFT));
            else if (pick < 75)
               a = $urandom;
            else if (pick < 85)
               a = base[ADDR_W-1:0] | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
            else if (pick < 92)
               a = ($urandom_range(1) == 0) ? region_top_q :
                   ADDR_W'(({32'h0, region_top_q} & ~(PAGE_BYTES - 1)) - PAGE_BYTES);
            else
               a = ($urandom_range(1) == 0) ? region_start_q :
                   region_start_q - ADDR_W'(PAGE_BYTES);
            queue_req(FUNC_FREE, a);
         end
      end
   endtask

   // request driver; the model advances on each accepted beat
   always @(posedge clock) begin : drive_req
      page_req_type beat;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.func      <= 1'b0;
         req_if.page_addr <= '0;
      end else begin
         if (req_if.valid && req_if.ready)
            alloc_outcomes_q.push_back(next_alloc_outcome(req_if.func, req_if.page_addr));
         if (!req_if.valid || req_if.ready) begin
            if (page_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               beat              = page_req_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.func      <= beat.func;
               req_if.page_addr <= beat.page_addr;
            end else begin
               req_if.valid     <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      alloc_outcome_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (alloc_outcomes_q.size() == 0) begin
               note_mismatch("unexpected beat", rsp_if.status, rsp_if.result_addr, '0);
            end else begin
               want = alloc_outcomes_q.pop_front();
               if (rsp_if.status !== want.status || rsp_if.result_addr !== want.addr)
                  note_mismatch("mismatch", rsp_if.status, rsp_if.result_addr, want);
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: only counts while work is outstanding
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_MAX) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stalled = 0;
         else if (page_req_q.size() != 0 || alloc_outcomes_q.size() != 0 || req_if.valid)
            stalled++;
         else
            stalled = 0;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [63:0] lo;
      logic [63:0] hi;
      req_if.valid     = 1'b0;
      req_if.func      = 1'b0;
      req_if.page_addr = '0;
      rsp_if.ready     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default region: fresh pages, bad frees on every side of the window
      queue_req(FUNC_ALLOC, 32'h0);
      queue_req(FUNC_ALLOC, 32'hFFFF_FFFF);
      queue_req(FUNC_ALLOC, 32'h0);
      queue_req(FUNC_FREE,  32'h8000_0000);
      queue_req(FUNC_FREE,  32'h8000_0001);
      queue_req(FUNC_FREE,  32'h7FFF_F000);
      queue_req(FUNC_FREE,  32'h8800_0000);
      queue_req(FUNC_FREE,  32'h87FF_F000);
      queue_req(FUNC_FREE,  32'h0000_0000);
      queue_req(FUNC_FREE,  32'hFFFF_F000);
      queue_req(FUNC_FREE,  32'hFFFF_FFFF);
      queue_req(FUNC_ALLOC, 32'h0);
      wait_idle();

      // start rounds past 4 GiB: no fresh pages, ring drains, then empty
      write_region(CSR_REGION_START, 32'hFFFF_FFFF);
      write_region(CSR_REGION_TOP,   32'hFFFF_FFFF);
      queue_req(FUNC_ALLOC, 32'h0);
      queue_req(FUNC_ALLOC, 32'h0);
      queue_req(FUNC_ALLOC, 32'h0);
      queue_req(FUNC_FREE,  32'hFFFF_F000);
      queue_req(FUNC_FREE,  32'hFFFF_FFFF);
      wait_idle();

      write_region(CSR_REGION_START, 32'h0);
      write_region(CSR_REGION_TOP,   32'h0);
      queue_req(FUNC_ALLOC, 32'h0);
      queue_req(FUNC_FREE,  32'h0);
      wait_idle();

      // whole address space: capped fresh count, double free of a fresh page
      write_region(CSR_REGION_TOP, 32'hFFFF_FFFF);
      queue_req(FUNC_ALLOC, 32'h0);
      queue_req(FUNC_FREE,  32'hFFFF_F000);
      queue_req(FUNC_FREE,  32'h0000_0000);
      queue_req(FUNC_FREE,  32'h0000_0000);
      queue_req(FUNC_ALLOC, 32'h0);
      wait_idle();

      // random phases over small windows, sender pauses to drain mid-phase
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 64 : 0;
         recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 15 : 0;
         lo = 64'($urandom);
         if ($urandom_range(1) == 0) lo[PAGE_SHIFT-1:0] = '0;
         hi = ((lo + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1)) +
              64'($urandom_range(4, 96)) * PAGE_BYTES;
         if ($urandom_range(3) == 0) hi = hi + 64'($urandom_range(PAGE_BYTES - 1));
         if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
         write_region(CSR_REGION_START, lo[ADDR_W-1:0]);
         write_region(CSR_REGION_TOP,   hi[ADDR_W-1:0]);
         queue_random_reqs(RAND_ITEMS / 2);
         wait_idle();
         queue_random_reqs(RAND_ITEMS - RAND_ITEMS / 2);
         wait_idle();
      end

      // eight-page window: queue frees, then drain fresh pages and ring to empty
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_region(CSR_REGION_START, 32'h4000_0000);
      write_region(CSR_REGION_TOP,   32'h4000_8000);
      for (int k = 0; k < 16; k++)
         queue_req(FUNC_FREE, 32'h4000_0000 + (32'($urandom_range(7)) << PAGE_SHIFT));
      for (int k = 0; k < 40; k++)
         queue_req(FUNC_ALLOC, $urandom);
      wait_idle();

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
src/fpfa_pkg.sv
src/fpfa_ifs.sv
src/fpfa_ring_ram.sv
src/fifo_page_frame_allocator.sv
src/fpfa_checker.sv
test/fifo_page_frame_allocator_tb.sv
